@@ design/ber_tlv_header_parser_assert.svh @@
// Assertion macros for the parser back end.
// Each expects clk and arst_n in scope.
`ifndef BER_TLV_HEADER_PARSER_ASSERT_SVH
`define BER_TLV_HEADER_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTLV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTLV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/btlv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package btlv_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [3:0] ERR_NONE          = 4'd0;
	localparam logic [3:0] ERR_SHORT_BUFFER  = 4'd1;
	localparam logic [3:0] ERR_TAG_TRUNC     = 4'd2;
	localparam logic [3:0] ERR_LEN_TOO_MANY  = 4'd3;
	localparam logic [3:0] ERR_LEN_TRUNC     = 4'd4;
	localparam logic [3:0] ERR_LEN_ZERO_CNT  = 4'd5;
	localparam logic [3:0] ERR_LONG_LEN_ZERO = 4'd6;
	localparam logic [3:0] ERR_PAYLOAD_PAST  = 4'd7;
	localparam logic [3:0] ERR_TAG_WIDE      = 4'd8;

	localparam logic [4:0] TAG_ESCAPE = 5'h1F;

	typedef struct packed {
		logic [7:0] data;
		logic       eob;
		logic       short_tag;
		logic       cnt_over;
		logic       cnt_zero;
	} btlv_entry_t;

endpackage
`default_nettype wire

@@ design/btlv_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module btlv_front import btlv_pkg::*; #(
	parameter int MAX_LENGTH_OCTETS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	input  wire logic        q_full,
	output logic             push,
	output btlv_entry_t      push_entry
);

	logic        v_s1;
	btlv_entry_t entry_s1;

	assign push       = v_s1 && !q_full;
	assign in_ready   = !v_s1 || !q_full;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// classify the byte for every role it may play in the header
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1.data      <= data_byte;
			entry_s1.eob       <= end_of_buffer;
			entry_s1.short_tag <= data_byte[4:0] != TAG_ESCAPE;
			entry_s1.cnt_over  <= data_byte[6:0] > 7'(MAX_LENGTH_OCTETS);
			entry_s1.cnt_zero  <= data_byte[6:0] == 7'd0;
		end
	end

endmodule
`default_nettype wire

@@ design/btlv_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module btlv_queue import btlv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  btlv_entry_t       push_entry,
	output logic              full,
	input  wire logic         pop,
	output logic              q_valid,
	output btlv_entry_t       pop_entry
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	btlv_entry_t   slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign q_valid   = count_q != '0;
	assign pop_entry = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= PW'((int'(wptr_q) + 1) % QUEUE_DEPTH);
			end
			if (pop) begin
				rptr_q <= PW'((int'(rptr_q) + 1) % QUEUE_DEPTH);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

@@ design/btlv_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "ber_tlv_header_parser_assert.svh"
module btlv_back import btlv_pkg::*; #(
	parameter int TAG_BITS          = 32,
	parameter int MAX_LENGTH_OCTETS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  btlv_entry_t      entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       tag_class,
	output logic             constructed,
	output logic [31:0]      tag_number,
	output logic [31:0]      content_length,
	output logic [7:0]       payload_byte,
	output logic [3:0]       error_code,
	output logic             last
);

	localparam int LW = 8 * MAX_LENGTH_OCTETS;

	localparam logic [2:0] PH_FIRST     = 3'd0;
	localparam logic [2:0] PH_TAG       = 3'd1;
	localparam logic [2:0] PH_LEN_FIRST = 3'd2;
	localparam logic [2:0] PH_LEN_MORE  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD   = 3'd4;
	localparam logic [2:0] PH_DROP      = 3'd5;

	logic [2:0]          phase_q, phase_n;
	logic [1:0]          class_q, class_n;
	logic                cons_q, cons_n;
	logic [TAG_BITS-1:0] tag_q, tag_n;
	logic [LW-1:0]       len_q, len_n;
	logic [3:0]          lol_q, lol_n;
	logic [LW-1:0]       pl_q, pl_n;

	logic       res_v;
	logic [1:0] res_kind;
	logic [7:0] res_pb;
	logic [3:0] res_err;
	logic       res_last;
	logic       hdr_go;
	logic [7:0] b;
	logic       eob;

	assign pop = q_valid && (!out_valid || out_ready);
	assign b   = entry.data;
	assign eob = entry.eob;

	always_comb begin
		phase_n  = phase_q;
		class_n  = class_q;
		cons_n   = cons_q;
		tag_n    = tag_q;
		len_n    = len_q;
		lol_n    = lol_q;
		pl_n     = pl_q;
		res_v    = 1'b0;
		res_kind = KIND_HEADER;
		res_pb   = 8'd0;
		res_err  = ERR_NONE;
		res_last = 1'b0;
		hdr_go   = 1'b0;
		unique case (phase_q)
			PH_FIRST: begin
				class_n = b[7:6];
				cons_n  = b[5];
				tag_n   = '0;
				len_n   = '0;
				lol_n   = '0;
				pl_n    = '0;
				if (eob) begin
					res_v   = 1'b1;
					res_err = ERR_SHORT_BUFFER;
				end else if (entry.short_tag) begin
					tag_n   = TAG_BITS'(b[4:0]);
					phase_n = PH_LEN_FIRST;
				end else begin
					phase_n = PH_TAG;
				end
			end
			PH_TAG: begin
				if ((tag_q >> (TAG_BITS - 7)) != '0) begin
					res_v   = 1'b1;
					res_err = ERR_TAG_WIDE;
				end else begin
					tag_n = TAG_BITS'({tag_q, b[6:0]});
					if (b[7]) begin
						if (eob) begin
							res_v   = 1'b1;
							res_err = ERR_TAG_TRUNC;
						end
					end else if (eob) begin
						res_v   = 1'b1;
						res_err = ERR_LEN_TRUNC;
					end else begin
						phase_n = PH_LEN_FIRST;
					end
				end
			end
			PH_LEN_FIRST: begin
				if (!b[7]) begin
					len_n  = LW'(b);
					hdr_go = 1'b1;
				end else if (entry.cnt_over) begin
					res_v   = 1'b1;
					res_err = ERR_LEN_TOO_MANY;
				end else if (entry.cnt_zero) begin
					res_v   = 1'b1;
					res_err = ERR_LEN_ZERO_CNT;
				end else if (eob) begin
					res_v   = 1'b1;
					res_err = ERR_LEN_TRUNC;
				end else begin
					lol_n   = b[3:0];
					len_n   = '0;
					phase_n = PH_LEN_MORE;
				end
			end
			PH_LEN_MORE: begin
				len_n = LW'({len_q, b});
				lol_n = (lol_q != 4'd0) ? lol_q - 4'd1 : lol_q;
				if (lol_n == 4'd0) begin
					if (len_n == '0) begin
						res_v   = 1'b1;
						res_err = ERR_LONG_LEN_ZERO;
					end else begin
						hdr_go = 1'b1;
					end
				end else if (eob) begin
					res_v   = 1'b1;
					res_err = ERR_LEN_TRUNC;
				end
			end
			PH_PAYLOAD: begin
				if (pl_q > LW'(1) && eob) begin
					res_v   = 1'b1;
					res_err = ERR_PAYLOAD_PAST;
				end else begin
					res_v    = 1'b1;
					res_kind = KIND_PAYLOAD;
					res_pb   = b;
					res_last = pl_q <= LW'(1);
					pl_n     = (pl_q != '0) ? pl_q - LW'(1) : pl_q;
					if (res_last) begin
						phase_n = PH_DROP;
					end
				end
			end
			default: begin
				phase_n = PH_DROP;
			end
		endcase

		if (res_err != ERR_NONE) begin
			res_kind = KIND_ERROR;
			res_last = 1'b1;
			phase_n  = PH_DROP;
		end

		if (hdr_go) begin
			res_v = 1'b1;
			if (len_n == '0) begin
				res_last = 1'b1;
				phase_n  = PH_DROP;
			end else if (eob) begin
				res_kind = KIND_ERROR;
				res_err  = ERR_PAYLOAD_PAST;
				res_last = 1'b1;
				phase_n  = PH_DROP;
			end else begin
				pl_n    = len_n;
				phase_n = PH_PAYLOAD;
			end
		end

		if (eob) begin
			phase_n = PH_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			class_q   <= '0;
			cons_q    <= 1'b0;
			tag_q     <= '0;
			len_q     <= '0;
			lol_q     <= '0;
			pl_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_n;
				class_q <= class_n;
				cons_q  <= cons_n;
				tag_q   <= tag_n;
				len_q   <= len_n;
				lol_q   <= lol_n;
				pl_q    <= pl_n;
			end
			if (pop && res_v) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_v) begin
			kind         <= res_kind;
			payload_byte <= res_pb;
			error_code   <= res_err;
			last         <= res_last;
			if (res_kind == KIND_ERROR) begin
				tag_class      <= '0;
				constructed    <= 1'b0;
				tag_number     <= '0;
				content_length <= '0;
			end else begin
				tag_class      <= class_n;
				constructed    <= cons_n;
				tag_number     <= 32'(tag_n);
				content_length <= 32'(len_n);
			end
		end
	end

	`BTLV_ASSERT_NOW(a_err_clean, out_valid && kind == KIND_ERROR,
		tag_number == '0 && content_length == '0 && last, "error item not cleared")
	`BTLV_ASSERT_NOW(a_payload_left, phase_q == PH_PAYLOAD, pl_q != '0,
		"payload phase with no bytes left")
	`BTLV_ASSERT_NEXT(a_eob_restart, pop && eob, phase_q == PH_FIRST,
		"buffer end did not restart parser")

endmodule
`default_nettype wire

@@ design/ber_tlv_header_parser.sv @@
// BER TLV header parser.
// Input channel (in_valid/in_ready): one buffer byte per item in data_byte,
// end_of_buffer set on the buffer's final byte.
// Output channel (out_valid/out_ready): at most one item per input byte;
// kind gives header, payload byte or error, with the element's class,
// constructed bit, tag number and content length, or an error code.
// last marks the final item of an element and every error.
// Throughput: one byte per cycle while the receiver takes results, set by
// the back-end parser, which handles one byte per pop. A result passes
// through the classify register, a queue slot and the output register.
// A four-entry queue sits between the classifier and the parser; when the
// receiver stalls the output register holds, the parser stops popping and
// the input keeps taking bytes until the queue and classify stage are full.
// Reset clears the queue and output valid and leaves the parser expecting
// the first tag octet of a new buffer. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module ber_tlv_header_parser import btlv_pkg::*; #(
	parameter int TAG_BITS          = 32,
	parameter int MAX_LENGTH_OCTETS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_buffer,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       tag_class,
	output logic             constructed,
	output logic [31:0]      tag_number,
	output logic [31:0]      content_length,
	output logic [7:0]       payload_byte,
	output logic [3:0]       error_code,
	output logic             last
);

	logic        q_full;
	logic        push;
	btlv_entry_t push_entry;
	logic        pop;
	logic        q_valid;
	btlv_entry_t pop_entry;

	btlv_front #(
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_buffer(end_of_buffer),
		.q_full       (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	btlv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.pop_entry (pop_entry)
	);

	btlv_back #(
		.TAG_BITS         (TAG_BITS),
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.entry         (pop_entry),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tag_class     (tag_class),
		.constructed   (constructed),
		.tag_number    (tag_number),
		.content_length(content_length),
		.payload_byte  (payload_byte),
		.error_code    (error_code),
		.last          (last)
	);

endmodule
`default_nettype wire
